### rtl/core/sbt_pkg.sv
// ----------------------------------------------------------------------------
// sbt_pkg
// Shared types, codes and helpers of the source byte tokenizer.
// ----------------------------------------------------------------------------
package sbt_pkg;

   localparam int unsigned POS_BITS      = 16;
   localparam int unsigned PREFIX_BYTES  = 6;
   localparam int unsigned PREFIX_BITS   = 8 * PREFIX_BYTES;
   localparam int unsigned QUEUE_DEPTH   = 2;
   localparam int unsigned QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   typedef logic [POS_BITS-1:0] pos_type;

   localparam pos_type POS_ONE  = pos_type'(1);
   localparam pos_type POS_ZERO = '0;
   localparam pos_type POS_MAX  = '1;

   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_HASH       = 8'h23;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

   localparam logic [PREFIX_BITS-1:0] WORD_DO     = PREFIX_BITS'(48'h646F);
   localparam logic [PREFIX_BITS-1:0] WORD_IF     = PREFIX_BITS'(48'h6966);
   localparam logic [PREFIX_BITS-1:0] WORD_FN     = PREFIX_BITS'(48'h666E);
   localparam logic [PREFIX_BITS-1:0] WORD_VAR    = PREFIX_BITS'(48'h766172);
   localparam logic [PREFIX_BITS-1:0] WORD_RETURN = PREFIX_BITS'(48'h72657475726E);

   localparam logic [4:0] KIND_EOF      = 5'd0;
   localparam logic [4:0] KIND_ID       = 5'd1;
   localparam logic [4:0] KIND_DO       = 5'd2;
   localparam logic [4:0] KIND_IF       = 5'd3;
   localparam logic [4:0] KIND_FN       = 5'd4;
   localparam logic [4:0] KIND_RETURN   = 5'd5;
   localparam logic [4:0] KIND_VAR      = 5'd6;
   localparam logic [4:0] KIND_NUMBER   = 5'd7;
   localparam logic [4:0] KIND_LPAREN   = 5'd8;
   localparam logic [4:0] KIND_RPAREN   = 5'd9;
   localparam logic [4:0] KIND_LBRACE   = 5'd10;
   localparam logic [4:0] KIND_RBRACE   = 5'd11;
   localparam logic [4:0] KIND_LBRACKET = 5'd12;
   localparam logic [4:0] KIND_RBRACKET = 5'd13;
   localparam logic [4:0] KIND_COMMA    = 5'd14;
   localparam logic [4:0] KIND_COLON    = 5'd15;
   localparam logic [4:0] KIND_SEMI     = 5'd16;

   typedef enum logic [3:0] {
      CLS_NEWLINE,
      CLS_SPACE,
      CLS_HASH,
      CLS_ALPHA,
      CLS_UNDERSCORE,
      CLS_DIGIT,
      CLS_PUNCT,
      CLS_OTHER,
      CLS_END
   } class_type;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_IDENT   = 3'd1,
      MODE_NUMBER  = 3'd2,
      MODE_COMMENT = 3'd3,
      MODE_HALTED  = 3'd4
   } mode_type;

   typedef struct packed {
      class_type  cls;
      logic [7:0] in_byte;
      logic [4:0] punct_kind;
   } item_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic        is_error;
      logic [7:0]  bad_char;
      logic [15:0] line_no;
      logic [15:0] column_no;
      logic [15:0] token_len;
      logic        last_of_run;
   } result_type;

   function automatic pos_type sat_inc(input pos_type v);
      return (v == POS_MAX) ? v : v + POS_ONE;
   endfunction

   function automatic logic [15:0] to_out16(input pos_type v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
   endfunction

endpackage

### rtl/core/sbt_if.sv
// ----------------------------------------------------------------------------
// sbt_if
// Request and response channels of the source byte tokenizer.
// ----------------------------------------------------------------------------
interface sbt_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] in_byte;

   modport source (output valid, output action, output in_byte, input ready);
   modport sink   (input valid, input action, input in_byte, output ready);
endinterface

interface sbt_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  token_kind;
   logic        is_error;
   logic [7:0]  bad_char;
   logic [15:0] line_no;
   logic [15:0] column_no;
   logic [15:0] token_len;
   logic        last_of_run;

   modport source (output valid, output token_kind, output is_error, output bad_char,
                   output line_no, output column_no, output token_len,
                   output last_of_run, input ready);
   modport sink   (input valid, input token_kind, input is_error, input bad_char,
                   input line_no, input column_no, input token_len,
                   input last_of_run, output ready);
endinterface

### rtl/core/sbt_front.sv
// ----------------------------------------------------------------------------
// sbt_front
// Accepts requests and classifies each byte into a character class.
// ----------------------------------------------------------------------------
module sbt_front
   import sbt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   sbt_req_if.sink      req_bus,
   output logic         push_valid,
   output item_type     push_item,
   input  logic         push_ready
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   item_type item_in;
   logic     accept;

   function automatic item_type classify(input logic action, input logic [7:0] b);
      item_type it;
      it.in_byte    = b;
      it.punct_kind = KIND_EOF;
      it.cls        = CLS_OTHER;
      if (action) begin
         it.cls = CLS_END;
      end else if (b == CHAR_NEWLINE) begin
         it.cls = CLS_NEWLINE;
      end else if (b inside {8'h20, [8'h09:8'h0D]}) begin
         it.cls = CLS_SPACE;
      end else if (b == CHAR_HASH) begin
         it.cls = CLS_HASH;
      end else if (b inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
         it.cls = CLS_ALPHA;
      end else if (b == CHAR_UNDERSCORE) begin
         it.cls = CLS_UNDERSCORE;
      end else if (b inside {[8'h30:8'h39]}) begin
         it.cls = CLS_DIGIT;
      end else begin
         case (b)
            8'h28:   it.punct_kind = KIND_LPAREN;
            8'h29:   it.punct_kind = KIND_RPAREN;
            8'h7B:   it.punct_kind = KIND_LBRACE;
            8'h7D:   it.punct_kind = KIND_RBRACE;
            8'h5B:   it.punct_kind = KIND_LBRACKET;
            8'h5D:   it.punct_kind = KIND_RBRACKET;
            8'h2C:   it.punct_kind = KIND_COMMA;
            8'h3A:   it.punct_kind = KIND_COLON;
            8'h3B:   it.punct_kind = KIND_SEMI;
            default: it.punct_kind = KIND_EOF;
         endcase
         if (it.punct_kind != KIND_EOF) begin
            it.cls = CLS_PUNCT;
         end
      end
      return it;
   endfunction

   assign req_bus.ready = !valid_ff || push_ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign push_valid    = valid_ff;
   assign push_item     = item_ff;

   always_comb begin
      valid_in = valid_ff && !push_ready;
      item_in  = item_ff;
      if (accept) begin
         valid_in = 1'b1;
         item_in  = classify(req_bus.action, req_bus.in_byte);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

### rtl/core/sbt_queue.sv
// ----------------------------------------------------------------------------
// sbt_queue
// Short register queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module sbt_queue
   import sbt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  item_type in_item,
   output logic     in_ready,
   output logic     out_valid,
   output item_type out_item,
   input  logic     out_pop
);

   item_type               slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff;
   logic [QPTR_BITS-1:0]   wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff;
   logic [QPTR_BITS-1:0]   rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff;
   logic [QCNT_BITS-1:0]   count_in;
   logic                   push;
   logic                   pop;

   function automatic logic [QPTR_BITS-1:0] next_ptr(input logic [QPTR_BITS-1:0] p);
      return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
   endfunction

   assign in_ready  = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

### rtl/core/sbt_back.sv
// ----------------------------------------------------------------------------
// sbt_back
// Scanner state machine, token assembly and the response output stage.
// ----------------------------------------------------------------------------
module sbt_back
   import sbt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   input  item_type     q_item,
   output logic         q_pop,
   sbt_rsp_if.source    rsp_bus
);

   mode_type                 mode_ff, mode_in, mode_nx;
   pos_type                  line_ff, line_in, line_nx;
   pos_type                  col_ff, col_in, col_nx;
   pos_type                  tline_ff, tline_in, tline_nx;
   pos_type                  tcol_ff, tcol_in, tcol_nx;
   pos_type                  tlen_ff, tlen_in, tlen_nx;
   logic [PREFIX_BITS-1:0]   prefix_ff, prefix_in, prefix_nx;

   result_type               out_ff, out_in;
   logic                     out_valid_ff, out_valid_in;
   result_type               spare_ff, spare_in;
   logic                     spare_valid_ff, spare_valid_in;

   mode_type                 i_mode;
   pos_type                  i_line, i_col, i_tline, i_tcol, i_tlen;
   logic [PREFIX_BITS-1:0]   i_prefix;
   logic                     i_emit;
   result_type               i_res;

   result_type               flush_res, eof_res, r0, r1;
   logic [4:0]               word_kind;
   logic [1:0]               n_res;
   logic                     can_load;
   logic                     commit;

   function automatic result_type make_result(input logic [4:0] kind, input logic err,
                                              input logic [7:0] bad, input pos_type ln,
                                              input pos_type col, input pos_type len);
      result_type r;
      r.token_kind  = kind;
      r.is_error    = err;
      r.bad_char    = bad;
      r.line_no     = to_out16(ln);
      r.column_no   = to_out16(col);
      r.token_len   = to_out16(len);
      r.last_of_run = 1'b0;
      return r;
   endfunction

   always_comb begin
      word_kind = KIND_ID;
      if (tlen_ff == pos_type'(2)) begin
         if (prefix_ff == WORD_DO) begin
            word_kind = KIND_DO;
         end else if (prefix_ff == WORD_IF) begin
            word_kind = KIND_IF;
         end else if (prefix_ff == WORD_FN) begin
            word_kind = KIND_FN;
         end
      end else if (tlen_ff == pos_type'(3)) begin
         if (prefix_ff == WORD_VAR) begin
            word_kind = KIND_VAR;
         end
      end else if (tlen_ff == pos_type'(PREFIX_BYTES)) begin
         if (prefix_ff == WORD_RETURN) begin
            word_kind = KIND_RETURN;
         end
      end
   end

   // Scan of one byte from the idle mode, shared by every mode that ends a token.
   always_comb begin
      i_mode   = MODE_IDLE;
      i_line   = line_ff;
      i_col    = col_ff;
      i_tline  = tline_ff;
      i_tcol   = tcol_ff;
      i_tlen   = tlen_ff;
      i_prefix = prefix_ff;
      i_emit   = 1'b0;
      i_res    = make_result(KIND_EOF, 1'b0, 8'd0, line_ff, col_ff, POS_ZERO);
      case (q_item.cls)
         CLS_NEWLINE: begin
            i_line = sat_inc(line_ff);
            i_col  = POS_ONE;
         end
         CLS_SPACE: begin
            i_col = sat_inc(col_ff);
         end
         CLS_HASH: begin
            i_mode = MODE_COMMENT;
            i_col  = sat_inc(col_ff);
         end
         CLS_ALPHA, CLS_UNDERSCORE, CLS_DIGIT: begin
            i_mode   = (q_item.cls == CLS_DIGIT) ? MODE_NUMBER : MODE_IDENT;
            i_tline  = line_ff;
            i_tcol   = col_ff;
            i_tlen   = POS_ONE;
            i_prefix = PREFIX_BITS'(q_item.in_byte);
            i_col    = sat_inc(col_ff);
         end
         CLS_PUNCT: begin
            i_emit = 1'b1;
            i_res  = make_result(q_item.punct_kind, 1'b0, 8'd0, line_ff, col_ff, POS_ONE);
            i_col  = sat_inc(col_ff);
         end
         default: begin
            i_mode = MODE_HALTED;
            i_emit = 1'b1;
            i_res  = make_result(KIND_EOF, 1'b1, q_item.in_byte, line_ff, col_ff, POS_ZERO);
         end
      endcase
   end

   always_comb begin
      mode_nx   = mode_ff;
      line_nx   = line_ff;
      col_nx    = col_ff;
      tline_nx  = tline_ff;
      tcol_nx   = tcol_ff;
      tlen_nx   = tlen_ff;
      prefix_nx = prefix_ff;
      n_res     = 2'd0;
      flush_res = make_result((mode_ff == MODE_IDENT) ? word_kind : KIND_NUMBER, 1'b0, 8'd0,
                              tline_ff, tcol_ff, tlen_ff);
      eof_res   = make_result(KIND_EOF, 1'b0, 8'd0, line_ff, POS_ONE, POS_ZERO);
      r0        = i_res;
      r1        = i_res;
      if (q_item.cls == CLS_END) begin
         if (mode_ff == MODE_IDENT || mode_ff == MODE_NUMBER) begin
            n_res = 2'd2;
            r0    = flush_res;
            r1    = eof_res;
         end else if (mode_ff != MODE_HALTED) begin
            n_res = 2'd1;
            r0    = eof_res;
         end
         mode_nx   = MODE_IDLE;
         line_nx   = POS_ONE;
         col_nx    = POS_ONE;
         tline_nx  = POS_ONE;
         tcol_nx   = POS_ONE;
         tlen_nx   = POS_ZERO;
         prefix_nx = '0;
      end else begin
         case (mode_ff)
            MODE_HALTED: begin
            end
            MODE_COMMENT: begin
               if (q_item.cls == CLS_NEWLINE) begin
                  mode_nx = i_mode;
                  line_nx = i_line;
                  col_nx  = i_col;
               end else begin
                  col_nx = sat_inc(col_ff);
               end
            end
            MODE_IDENT, MODE_NUMBER: begin
               if ((q_item.cls == CLS_DIGIT) ||
                   (mode_ff == MODE_IDENT &&
                    (q_item.cls == CLS_ALPHA || q_item.cls == CLS_UNDERSCORE))) begin
                  if (tlen_ff < pos_type'(PREFIX_BYTES)) begin
                     prefix_nx = {prefix_ff[PREFIX_BITS-9:0], q_item.in_byte};
                  end
                  tlen_nx = sat_inc(tlen_ff);
                  col_nx  = sat_inc(col_ff);
               end else if (mode_ff == MODE_NUMBER && q_item.cls == CLS_ALPHA) begin
                  mode_nx = MODE_HALTED;
                  n_res   = 2'd1;
                  r0      = make_result(KIND_EOF, 1'b1, q_item.in_byte, line_ff, col_ff,
                                        POS_ZERO);
               end else begin
                  mode_nx   = i_mode;
                  line_nx   = i_line;
                  col_nx    = i_col;
                  tline_nx  = i_tline;
                  tcol_nx   = i_tcol;
                  tlen_nx   = i_tlen;
                  prefix_nx = i_prefix;
                  n_res     = i_emit ? 2'd2 : 2'd1;
                  r0        = flush_res;
                  r1        = i_res;
               end
            end
            default: begin
               mode_nx   = i_mode;
               line_nx   = i_line;
               col_nx    = i_col;
               tline_nx  = i_tline;
               tcol_nx   = i_tcol;
               tlen_nx   = i_tlen;
               prefix_nx = i_prefix;
               n_res     = i_emit ? 2'd1 : 2'd0;
               r0        = i_res;
            end
         endcase
      end
      r0.last_of_run = (n_res == 2'd1);
      r1.last_of_run = 1'b1;
   end

   // A request that yields two responses parks the second one in the spare register.
   always_comb begin
      can_load       = !out_valid_ff || rsp_bus.ready;
      out_in         = out_ff;
      out_valid_in   = out_valid_ff && !rsp_bus.ready;
      spare_in       = spare_ff;
      spare_valid_in = spare_valid_ff;
      commit         = 1'b0;
      if (spare_valid_ff) begin
         if (can_load) begin
            out_in         = spare_ff;
            out_valid_in   = 1'b1;
            spare_valid_in = 1'b0;
         end
      end else if (q_valid) begin
         if (n_res == 2'd0) begin
            commit = 1'b1;
         end else if (can_load) begin
            commit       = 1'b1;
            out_in       = r0;
            out_valid_in = 1'b1;
            if (n_res == 2'd2) begin
               spare_in       = r1;
               spare_valid_in = 1'b1;
            end
         end
      end
      q_pop     = commit;
      mode_in   = commit ? mode_nx   : mode_ff;
      line_in   = commit ? line_nx   : line_ff;
      col_in    = commit ? col_nx    : col_ff;
      tline_in  = commit ? tline_nx  : tline_ff;
      tcol_in   = commit ? tcol_nx   : tcol_ff;
      tlen_in   = commit ? tlen_nx   : tlen_ff;
      prefix_in = commit ? prefix_nx : prefix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         line_ff        <= POS_ONE;
         col_ff         <= POS_ONE;
         tline_ff       <= POS_ONE;
         tcol_ff        <= POS_ONE;
         tlen_ff        <= POS_ZERO;
         prefix_ff      <= '0;
         out_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         mode_ff        <= mode_in;
         line_ff        <= line_in;
         col_ff         <= col_in;
         tline_ff       <= tline_in;
         tcol_ff        <= tcol_in;
         tlen_ff        <= tlen_in;
         prefix_ff      <= prefix_in;
         out_valid_ff   <= out_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff   <= out_in;
      spare_ff <= spare_in;
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.token_kind  = out_ff.token_kind;
   assign rsp_bus.is_error    = out_ff.is_error;
   assign rsp_bus.bad_char    = out_ff.bad_char;
   assign rsp_bus.line_no     = out_ff.line_no;
   assign rsp_bus.column_no   = out_ff.column_no;
   assign rsp_bus.token_len   = out_ff.token_len;
   assign rsp_bus.last_of_run = out_ff.last_of_run;

endmodule

### rtl/core/source_byte_tokenizer.sv
// ----------------------------------------------------------------------------
// source_byte_tokenizer
// Streaming tokenizer: source bytes in, tokens with line, column and length out.
//
//   Channel  Direction  Payload
//   req_bus  in         action, in_byte
//   rsp_bus  out        token_kind, is_error, bad_char, line_no, column_no,
//                       token_len, last_of_run
//
// One request is taken per cycle while the queue has room; its responses pass
// through the front register, a queue slot and the output register.
// A request that yields two responses holds the scanner until the second one leaves the spare register.
// The front register and a two-entry queue let requests keep flowing during
// response stalls. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module source_byte_tokenizer
   import sbt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   sbt_req_if.sink   req_bus,
   sbt_rsp_if.source rsp_bus
);

   logic     push_valid;
   item_type push_item;
   logic     push_ready;
   logic     q_valid;
   item_type q_item;
   logic     q_pop;

   sbt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   sbt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_item   (push_item),
      .in_ready  (push_ready),
      .out_valid (q_valid),
      .out_item  (q_item),
      .out_pop   (q_pop)
   );

   sbt_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("Scanner consumed an entry from an empty queue.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.is_error) |->
         (rsp_bus.token_kind == KIND_EOF && rsp_bus.token_len == 16'd0))
      else $error("Error response carries a token kind or length.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.is_error) |-> (rsp_bus.bad_char == 8'd0))
      else $error("Token response carries a bad character.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && !rsp_bus.last_of_run) |=> rsp_bus.valid)
      else $error("Second response of a request did not follow at once.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.is_error && rsp_bus.token_kind == KIND_EOF) |->
         (rsp_bus.column_no == 16'd1 && rsp_bus.last_of_run))
      else $error("End-of-file response is malformed.");

endmodule

### test/tokenizer_checker.sv
// ----------------------------------------------------------------------------
// tokenizer_checker
// Watches the request and response channels of the source byte tokenizer.
// Each accepted request is run through a local scanner that keeps its own
// line, column and token state, and the tokens it yields are queued. Each
// accepted response is compared field by field with the oldest queued token.
// The failure count and the number of tokens still due go to the top.
// ----------------------------------------------------------------------------
module tokenizer_checker
   import sbt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   sbt_req_if          req_bus,
   sbt_rsp_if          rsp_bus,
   output int unsigned error_count,
   output int unsigned tokens_due
);
   timeunit 1ns;
   timeprecision 1ps;

   mode_type               scan_mode;
   pos_type                line_count;
   pos_type                column_count;
   pos_type                token_line;
   pos_type                token_column;
   pos_type                token_length;
   logic [PREFIX_BITS-1:0] word_prefix;
   result_type             run_tokens[$];
   result_type             expected_tokens[$];
   int unsigned            failures = 0;

   function automatic bit is_letter(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic bit is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic bit is_blank(input logic [7:0] b);
      return b == " " || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic pos_type bump(input pos_type v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [15:0] clip16(input pos_type v);
      return ((v >> 16) != 0) ? 16'hFFFF : 16'(v);
   endfunction

   function automatic logic [4:0] punct_kind(input logic [7:0] b);
      case (b)
         "(": return KIND_LPAREN;
         ")": return KIND_RPAREN;
         "{": return KIND_LBRACE;
         "}": return KIND_RBRACE;
         "[": return KIND_LBRACKET;
         "]": return KIND_RBRACKET;
         ",": return KIND_COMMA;
         ":": return KIND_COLON;
         ";": return KIND_SEMI;
         default: return KIND_EOF;
      endcase
   endfunction

   function automatic logic [4:0] word_kind();
      if (token_length == 2 && word_prefix == WORD_DO) return KIND_DO;
      if (token_length == 2 && word_prefix == WORD_IF) return KIND_IF;
      if (token_length == 2 && word_prefix == WORD_FN) return KIND_FN;
      if (token_length == 3 && word_prefix == WORD_VAR) return KIND_VAR;
      if (token_length == 6 && word_prefix == WORD_RETURN) return KIND_RETURN;
      return KIND_ID;
   endfunction

   task automatic add_token(input logic [4:0] kind, input logic fault, input logic [7:0] bad,
                            input pos_type at_line, input pos_type at_column,
                            input pos_type len);
      result_type r;
      r.token_kind  = kind;
      r.is_error    = fault;
      r.bad_char    = bad;
      r.line_no     = clip16(at_line);
      r.column_no   = clip16(at_column);
      r.token_len   = clip16(len);
      r.last_of_run = 1'b0;
      run_tokens.push_back(r);
   endtask

   task automatic restart_scan();
      scan_mode    = MODE_IDLE;
      line_count   = POS_ONE;
      column_count = POS_ONE;
      token_line   = POS_ONE;
      token_column = POS_ONE;
      token_length = POS_ZERO;
      word_prefix  = '0;
   endtask

   task automatic flush_word();
      if (scan_mode == MODE_IDENT) begin
         add_token(word_kind(), 1'b0, 8'h00, token_line, token_column, token_length);
      end else if (scan_mode == MODE_NUMBER) begin
         add_token(KIND_NUMBER, 1'b0, 8'h00, token_line, token_column, token_length);
      end
      scan_mode = MODE_IDLE;
   endtask

   task automatic start_token(input mode_type mode, input logic [7:0] b);
      scan_mode    = mode;
      token_line   = line_count;
      token_column = column_count;
      token_length = POS_ONE;
      word_prefix  = PREFIX_BITS'(b);
      column_count = bump(column_count);
   endtask

   task automatic extend_word(input logic [7:0] b);
      if (token_length < PREFIX_BYTES) word_prefix = {word_prefix[PREFIX_BITS-9:0], b};
      token_length = bump(token_length);
      column_count = bump(column_count);
   endtask

   task automatic scan_fresh(input logic [7:0] b);
      logic [4:0] kind;
      kind = punct_kind(b);
      if (b == CHAR_NEWLINE) begin
         line_count   = bump(line_count);
         column_count = POS_ONE;
      end else if (is_blank(b)) begin
         column_count = bump(column_count);
      end else if (b == CHAR_HASH) begin
         scan_mode    = MODE_COMMENT;
         column_count = bump(column_count);
      end else if (is_letter(b) || b == CHAR_UNDERSCORE) begin
         start_token(MODE_IDENT, b);
      end else if (is_digit(b)) begin
         start_token(MODE_NUMBER, b);
      end else if (kind == KIND_EOF) begin
         scan_mode = MODE_HALTED;
         add_token(KIND_EOF, 1'b1, b, line_count, column_count, POS_ZERO);
      end else begin
         add_token(kind, 1'b0, 8'h00, line_count, column_count, POS_ONE);
         column_count = bump(column_count);
      end
   endtask

   task automatic lex_request(input logic end_of_text, input logic [7:0] b);
      run_tokens.delete();
      if (end_of_text) begin
         if (scan_mode != MODE_HALTED) begin
            flush_word();
            add_token(KIND_EOF, 1'b0, 8'h00, line_count, POS_ONE, POS_ZERO);
         end
         restart_scan();
      end else begin
         case (scan_mode)
            MODE_HALTED: ;
            MODE_COMMENT: begin
               if (b == CHAR_NEWLINE) begin
                  scan_mode = MODE_IDLE;
                  scan_fresh(b);
               end else begin
                  column_count = bump(column_count);
               end
            end
            MODE_IDENT: begin
               if (is_letter(b) || is_digit(b) || b == CHAR_UNDERSCORE) begin
                  extend_word(b);
               end else begin
                  flush_word();
                  scan_fresh(b);
               end
            end
            MODE_NUMBER: begin
               if (is_digit(b)) begin
                  extend_word(b);
               end else if (is_letter(b)) begin
                  scan_mode = MODE_HALTED;
                  add_token(KIND_EOF, 1'b1, b, line_count, column_count, POS_ZERO);
               end else begin
                  flush_word();
                  scan_fresh(b);
               end
            end
            default: begin
               scan_mode = MODE_IDLE;
               scan_fresh(b);
            end
         endcase
      end
      if (run_tokens.size() > 0) run_tokens[run_tokens.size()-1].last_of_run = 1'b1;
      foreach (run_tokens[i]) expected_tokens.push_back(run_tokens[i]);
   endtask

   function automatic bit field_ok(input string field, input logic [15:0] want,
                                   input logic [15:0] got);
      if (want === got) return 1'b1;
      $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      result_type want;
      result_type got;
      bit         good;
      if (reset) begin
         restart_scan();
         expected_tokens.delete();
      end else begin
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            lex_request(req_bus.action, req_bus.in_byte);
         end
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.token_kind  = rsp_bus.token_kind;
            got.is_error    = rsp_bus.is_error;
            got.bad_char    = rsp_bus.bad_char;
            got.line_no     = rsp_bus.line_no;
            got.column_no   = rsp_bus.column_no;
            got.token_len   = rsp_bus.token_len;
            got.last_of_run = rsp_bus.last_of_run;
            if (expected_tokens.size() == 0) begin
               $display("%0t ns: token expected none, actual kind %0d at %0d:%0d",
                        $time, got.token_kind, got.line_no, got.column_no);
               failures++;
            end else begin
               want = expected_tokens.pop_front();
               good = field_ok("token_kind", 16'(want.token_kind), 16'(got.token_kind))
                    & field_ok("is_error", 16'(want.is_error), 16'(got.is_error))
                    & field_ok("bad_char", 16'(want.bad_char), 16'(got.bad_char))
                    & field_ok("line_no", want.line_no, got.line_no)
                    & field_ok("column_no", want.column_no, got.column_no)
                    & field_ok("token_len", want.token_len, got.token_len)
                    & field_ok("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
               if (!good) failures++;
            end
         end
      end
      error_count <= failures;
      tokens_due  <= expected_tokens.size();
   end

endmodule

### test/source_byte_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// source_byte_tokenizer_tb
// Drives source text into the tokenizer and gives the verdict. A short
// directed part covers errors, halting, comments at end of text and long
// identifiers; random programs of keywords, identifiers, numbers, punctuators,
// comments and blanks follow, with some noise. A last program runs with no
// idling on either side. Both channels idle at random, the receiver holds off
// once for a long stretch, and the checker does the rest.
// ----------------------------------------------------------------------------
module source_byte_tokenizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sbt_pkg::*;

   localparam logic        ACT_BYTE      = 1'b0;
   localparam logic        ACT_END       = 1'b1;
   localparam int unsigned RESET_CYCLES  = 6;
   localparam int unsigned IDLE_PERCENT  = 32;
   localparam int unsigned RANDOM_ITEMS  = 1300;
   localparam int unsigned STEADY_RUN    = 40;
   localparam int unsigned HOLD_START    = 600;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned SETTLE_CYCLES = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        steady = 1'b0;
   int unsigned items_sent = 0;
   int unsigned error_count;
   int unsigned tokens_due;

   string       keyword_list[5] = '{"do", "if", "fn", "return", "var"};
   string       punct_list = "(){}[],:;";
   logic [7:0]  blank_list[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

   sbt_req_if req_bus ();
   sbt_rsp_if rsp_bus ();

   source_byte_tokenizer DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   tokenizer_checker token_check (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .error_count (error_count),
      .tokens_due  (tokens_due)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] name_char(input bit leading);
      int unsigned pick;
      pick = $urandom_range(leading ? 52 : 62);
      if (pick < 26) return 8'h61 + 8'(pick);
      if (pick < 52) return 8'h41 + 8'(pick - 26);
      if (pick == 52) return CHAR_UNDERSCORE;
      return 8'h30 + 8'(pick - 53);
   endfunction

   task automatic push_request(input logic act, input logic [7:0] b);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.action  <= act;
      req_bus.in_byte <= b;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) push_request(ACT_BYTE, text[i]);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (tokens_due != 0);
   endtask

   initial begin
      int unsigned cycle_no;
      cycle_no = 0;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (cycle_no >= HOLD_START && cycle_no < HOLD_START + HOLD_CYCLES) begin
            rsp_bus.ready <= 1'b0;
         end else if (steady) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= IDLE_PERCENT);
         end
         cycle_no++;
         @(posedge clock);
      end
   end

   initial begin
      int unsigned pieces;
      int unsigned len;
      logic [7:0]  b;
      req_bus.valid   = 1'b0;
      req_bus.action  = ACT_BYTE;
      req_bus.in_byte = 8'h00;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      send_text("7a");
      push_request(ACT_BYTE, 8'hFF);
      push_request(ACT_END, 8'hA5);
      send_text("9_");
      push_request(ACT_END, 8'h00);
      push_request(ACT_BYTE, 8'h00);
      push_request(ACT_END, 8'hFF);
      send_text("#c");
      push_request(ACT_END, 8'h5A);
      send_text("fnabcdefg;");
      push_request(ACT_END, 8'h00);
      wait_drained();

      while (items_sent < RANDOM_ITEMS) begin
         pieces = $urandom_range(30, 3);
         repeat (pieces) begin
            case ($urandom_range(39))
               0: push_request(ACT_BYTE, 8'($urandom));
               1: begin
                  len = $urandom_range(4, 1);
                  repeat (len) push_request(ACT_BYTE, 8'h30 + 8'($urandom_range(9)));
                  push_request(ACT_BYTE, name_char(1'b1));
               end
               2, 3, 4, 5: begin
                  send_text(keyword_list[$urandom_range(4)]);
                  if ($urandom_range(3) == 0) push_request(ACT_BYTE, name_char(1'b0));
               end
               6, 7, 8, 9: begin
                  len = ($urandom_range(9) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
                  push_request(ACT_BYTE, name_char(1'b1));
                  repeat (len - 1) push_request(ACT_BYTE, name_char(1'b0));
               end
               10, 11, 12: begin
                  len = $urandom_range(6, 1);
                  repeat (len) push_request(ACT_BYTE, 8'h30 + 8'($urandom_range(9)));
               end
               13, 14, 15, 16, 17: push_request(ACT_BYTE, punct_list[$urandom_range(8)]);
               18, 19: begin
                  push_request(ACT_BYTE, CHAR_HASH);
                  len = $urandom_range(8);
                  repeat (len) begin
                     do b = 8'($urandom); while (b == CHAR_NEWLINE);
                     push_request(ACT_BYTE, b);
                  end
                  if ($urandom_range(5) != 0) push_request(ACT_BYTE, CHAR_NEWLINE);
               end
               default: push_request(ACT_BYTE, blank_list[$urandom_range(5)]);
            endcase
         end
         push_request(ACT_END, 8'($urandom));
         if ($urandom_range(7) == 0) wait_drained();
      end
      wait_drained();

      steady <= 1'b1;
      repeat (STEADY_RUN) push_request(ACT_BYTE, "q");
      send_text(" (\n");
      repeat (STEADY_RUN) push_request(ACT_BYTE, CHAR_NEWLINE);
      send_text("return 12");
      push_request(ACT_END, 8'h00);
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && tokens_due == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
